@@ sv/arpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and types for the address resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;
	localparam int CACHE_DEPTH   = 32;
	localparam int REQUEST_DEPTH = 16;
	localparam int AGE_WIDTH     = 16;
	localparam int CIDX_W        = $clog2(CACHE_DEPTH + 1);
	localparam int RIDX_W        = $clog2(REQUEST_DEPTH + 1);
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	localparam logic [2:0] FN_LOOKUP = 3'd0;
	localparam logic [2:0] FN_INSERT = 3'd1;
	localparam logic [2:0] FN_QUEUE  = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_TICK   = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;

	localparam logic [2:0] KD_LOOKUP = 3'd0;
	localparam logic [2:0] KD_INSERT = 3'd1;
	localparam logic [2:0] KD_QUEUE  = 3'd2;
	localparam logic [2:0] KD_REMOVE = 3'd3;
	localparam logic [2:0] KD_SEND   = 3'd4;
	localparam logic [2:0] KD_EXPIRE = 3'd5;
	localparam logic [2:0] KD_DONE   = 3'd6;

	localparam logic       REG_TIMEOUT = 1'b0;
	localparam logic       REG_MAXSEND = 1'b1;

	// operation presented to every cell of a row
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [1:0]  iface;
		logic [15:0] timeout;
		logic [2:0]  max_sends;
	} op_t;

	// token passed along the row
	typedef struct packed {
		logic        found;
		logic        placed;
		logic [47:0] mac;
	} ctok_t;

	typedef struct packed {
		logic        found;
		logic        placed;
	} rtok_t;
endpackage

@@ sv/arpc_entry_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_entry_cell
// One cache slot: match, first-free claim and ageing.
// ----------------------------------------------------------------------------
module arpc_entry_cell import arpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  op_t   op,
	input  ctok_t tin,
	output ctok_t tout
);
	logic                 valid_q;
	logic [31:0]          ip_q;
	logic [47:0]          mac_q;
	logic [AGE_WIDTH-1:0] age_q;
	logic [AGE_WIDTH-1:0] age_nx;
	logic                 match;

	assign match  = valid_q && ip_q == op.ip;
	assign age_nx = (age_q < AGE_MAX) ? age_q + 1'b1 : age_q;

	always_comb begin
		tout = tin;
		if (op.func == FN_LOOKUP && !tin.found && match) begin
			tout.found = 1'b1;
			tout.mac   = mac_q;
		end
		if (op.func == FN_INSERT && !tin.placed && !valid_q)
			tout.placed = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			case (op.func)
				FN_INSERT: if (!tin.placed && !valid_q) valid_q <= 1'b1;
				FN_TICK:   if (valid_q && {16'd0, age_nx} > {{AGE_WIDTH{1'b0}}, op.timeout})
					valid_q <= 1'b0;
				FN_CLEAR:  valid_q <= 1'b0;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (op.func == FN_INSERT && !tin.placed && !valid_q) begin
				ip_q  <= op.ip;
				mac_q <= op.mac;
				age_q <= '0;
			end else if (op.func == FN_TICK && valid_q) begin
				age_q <= age_nx;
			end
		end
	end
endmodule

@@ sv/arpc_req_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_req_cell
// One pending request slot; on a tick its report is loaded into a queue.
// ----------------------------------------------------------------------------
module arpc_req_cell import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  op_t         op,
	input  logic        known,
	input  rtok_t       tin,
	output rtok_t       tout,
	output logic        rep_v,
	output logic        rep_exp,
	output logic [31:0] rep_ip,
	output logic [1:0]  rep_if
);
	logic        valid_q;
	logic [31:0] ip_q;
	logic [1:0]  if_q;
	logic [2:0]  cnt_q;
	logic        match;
	logic        expire;
	logic        claim;

	assign match   = valid_q && ip_q == op.ip;
	assign expire  = cnt_q >= op.max_sends;
	assign claim   = op.func == FN_QUEUE && !known && !tin.placed && !valid_q;
	assign rep_v   = valid_q;
	assign rep_exp = expire;
	assign rep_ip  = ip_q;
	assign rep_if  = if_q;

	// a queue of a known address claims no slot
	always_comb begin
		tout = tin;
		if (match) tout.found = 1'b1;
		if (claim) tout.placed = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			case (op.func)
				FN_QUEUE:  if (claim) valid_q <= 1'b1;
				FN_REMOVE: if (match) valid_q <= 1'b0;
				FN_TICK:   if (valid_q && expire) valid_q <= 1'b0;
				FN_CLEAR:  valid_q <= 1'b0;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (claim) begin
				ip_q  <= op.ip;
				if_q  <= op.iface;
				cnt_q <= '0;
			end else if (op.func == FN_TICK && valid_q && !expire) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end
endmodule

@@ sv/arp_cache_with_request_retry_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_unit
// Address resolution cache with request retry, built as rows of slot cells.
// A single result is strobed in the cycle after the execute cycle. A tick
// reports the occupied request slots in slot order and then a done result,
// with at most one result a cycle; start is taken only while not busy.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// Results are strobed by valid; no stall.
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry_unit import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [1:0]  iface_index,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        valid,
	output logic [2:0]  kind,
	output logic        hit,
	output logic [47:0] mac_out,
	output logic [31:0] ip_out,
	output logic [1:0]  iface_out,
	output logic        full_res,
	output logic        last
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]  st_q;
	op_t         op_q;
	logic [15:0] timeout_q;
	logic [2:0]  maxs_q;
	logic        exec;
	ctok_t       ct [CACHE_DEPTH+1];
	rtok_t       rt [REQUEST_DEPTH+1];
	logic        rv [REQUEST_DEPTH];
	logic        rx [REQUEST_DEPTH];
	logic [31:0] ri [REQUEST_DEPTH];
	logic [1:0]  rf [REQUEST_DEPTH];
	// report queue shifted out one per cycle
	logic        qv_q [REQUEST_DEPTH];
	logic        qx_q [REQUEST_DEPTH];
	logic [31:0] qi_q [REQUEST_DEPTH];
	logic [1:0]  qf_q [REQUEST_DEPTH];
	logic        any_left;

	assign exec = st_q == ST_EXEC;
	assign busy = st_q != ST_IDLE;
	assign ct[0] = '0;
	assign rt[0] = '0;

	for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cache
		arpc_entry_cell u_cell (.clk, .arst_n, .en(exec), .op(op_q),
			.tin(ct[g]), .tout(ct[g+1]));
	end
	for (genvar g = 0; g < REQUEST_DEPTH; g++) begin : g_req
		arpc_req_cell u_cell (.clk, .arst_n, .en(exec), .op(op_q),
			.known(rt[REQUEST_DEPTH].found),
			.tin(rt[g]), .tout(rt[g+1]), .rep_v(rv[g]), .rep_exp(rx[g]),
			.rep_ip(ri[g]), .rep_if(rf[g]));
	end

	always_comb begin
		any_left = 1'b0;
		for (int k = 0; k < REQUEST_DEPTH; k++) any_left |= qv_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd30;
			maxs_q    <= 3'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MAXSEND: maxs_q    <= cfg_data[2:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			valid  <= 1'b0;
			for (int k = 0; k < REQUEST_DEPTH; k++) qv_q[k] <= 1'b0;
		end else begin
			valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start && func <= FN_CLEAR) st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (op_q.func == FN_TICK) begin
						for (int k = 0; k < REQUEST_DEPTH; k++) qv_q[k] <= rv[k];
						st_q   <= ST_DRAIN;
					end else begin
						valid <= 1'b1;
						st_q  <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					for (int k = 0; k < REQUEST_DEPTH - 1; k++) qv_q[k] <= qv_q[k+1];
					qv_q[REQUEST_DEPTH-1] <= 1'b0;
					valid <= qv_q[0] || !any_left;
					if (!any_left) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			op_q.func  <= func;
			op_q.ip    <= ip_addr;
			op_q.mac   <= mac_addr;
			op_q.iface <= iface_index;
		end
		op_q.timeout   <= timeout_q;
		op_q.max_sends <= maxs_q;
		if (exec) begin
			for (int k = 0; k < REQUEST_DEPTH; k++) begin
				qx_q[k] <= rx[k];
				qi_q[k] <= ri[k];
				qf_q[k] <= rf[k];
			end
		end else if (st_q == ST_DRAIN) begin
			for (int k = 0; k < REQUEST_DEPTH - 1; k++) begin
				qx_q[k] <= qx_q[k+1];
				qi_q[k] <= qi_q[k+1];
				qf_q[k] <= qf_q[k+1];
			end
		end
		kind <= KD_DONE; hit <= 1'b0; mac_out <= '0; ip_out <= '0;
		iface_out <= '0; full_res <= 1'b0; last <= 1'b1;
		if (exec) begin
			unique case (op_q.func)
				FN_LOOKUP: begin
					kind <= KD_LOOKUP;
					hit  <= ct[CACHE_DEPTH].found;
					mac_out <= ct[CACHE_DEPTH].found ? ct[CACHE_DEPTH].mac : 48'd0;
				end
				FN_INSERT: begin
					kind <= KD_INSERT;
					hit  <= rt[REQUEST_DEPTH].found;
					full_res <= !ct[CACHE_DEPTH].placed;
				end
				FN_QUEUE: begin
					kind <= KD_QUEUE;
					full_res <= !rt[REQUEST_DEPTH].found && !rt[REQUEST_DEPTH].placed;
				end
				FN_REMOVE: kind <= KD_REMOVE;
				default:   kind <= KD_DONE;
			endcase
		end else if (st_q == ST_DRAIN && any_left) begin
			kind <= qx_q[0] ? KD_EXPIRE : KD_SEND;
			ip_out <= qi_q[0];
			iface_out <= qf_q[0];
			last <= 1'b0;
		end
	end
endmodule
